[hdl/wab_pkg.sv]
`timescale 1ns / 1ps

package wab_pkg;

	// Field and datapath widths
	localparam int OP_W       = 2;
	localparam int CH_FIELD_W = 6;
	localparam int POS_W      = 9;
	localparam int SMP_W      = 16;
	localparam int SUM_W      = 24;
	localparam int BASE_W     = 29;
	localparam int NUM_W      = 31;
	localparam int MAG_W      = 30;
	localparam int DIV_W      = 13;
	localparam int CNT_W      = 8;
	localparam int STEP_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int AVG_W      = 16;

	// Number of leading positions that form the baseline window
	localparam int BASE_LEN = 30;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ACCUM = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT     = 1'd1;

	// Saturation limits
	localparam logic signed [AVG_W-1:0] AVG_MAX = 16'sh7FFF;
	localparam logic signed [AVG_W-1:0] AVG_MIN = 16'sh8000;

	typedef struct packed {
		logic [OP_W-1:0]              operation;
		logic [CH_FIELD_W-1:0]        channel;
		logic [POS_W-1:0]             sample_index;
		logic signed [SMP_W-1:0]      sample;
	} in_item_t;

	typedef struct packed {
		logic signed [AVG_W-1:0]      average;
		logic                         saturated;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_ACCUM,
		ST_NUMER,
		ST_SETUP,
		ST_DIVIDE,
		ST_RESULT
	} state_t;

endpackage

[hdl/waveform_averager_baseline.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_item   (operation, channel, position, sample)
// out       output     out_valid / out_ready out_item  (average, saturated)
// cfg       input      cfg_we                cfg_index, cfg_data (no wait, no read-back)
//
// Accumulate steps through accept, read of the sum memories and write-back; no new
// item is taken until it is done. An in-range read runs fetch, numerator, setup,
// divide and result, and the shared restoring divider retires one quotient bit per
// cycle. Clear sweeps the sum memory one entry per cycle, and the same sweep runs
// after reset before the first transfer is taken. A finished average waits in the
// output register, so a stalled out side blocks only the next read at its last step.
module waveform_averager_baseline #(
	parameter int CHANNELS = 37,
	parameter int SAMPLES  = 300
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  wab_pkg::in_item_t                    in_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output wab_pkg::out_item_t                   out_item,
	input  logic                                 cfg_we,
	input  logic [wab_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wab_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import wab_pkg::*;

	localparam int DEPTH  = CHANNELS * SAMPLES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Accumulator storage: one sum per channel and position, one baseline sum per channel
	logic [SUM_W-1:0]  sum_mem [DEPTH];
	logic [BASE_W-1:0] base_mem [CHANNELS];

	// Control
	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  cnt_q;
	logic [STEP_W-1:0]  step_q;
	logic               is_read_q;

	// Configuration
	logic               bl_en_q;
	logic [CNT_W-1:0]   ev_cnt_q;

	// Captured item
	logic [ADDR_W-1:0]       addr_q;
	logic [CH_W-1:0]         ch_q;
	logic                    base_win_q;
	logic signed [SMP_W-1:0] sample_q;

	// Datapath
	logic [SUM_W-1:0]        sum_rd_q;
	logic [BASE_W-1:0]       base_rd_q;
	logic signed [NUM_W-1:0] num_q;
	logic [DIV_W-1:0]        div_q;
	logic                    neg_q;
	logic [MAG_W-1:0]        quo_q;
	logic [DIV_W-1:0]        rem_q;

	// Output register
	logic       out_valid_q;
	out_item_t  out_q;

	// Combinational
	logic               accept;
	logic               item_ok;
	logic [ADDR_W-1:0]  addr_in;
	logic               sum_we, base_we, load_out, sweep_last;
	logic [ADDR_W-1:0]  sum_waddr;
	logic [CH_W-1:0]    base_waddr;
	logic [SUM_W-1:0]   sum_wdata;
	logic [BASE_W-1:0]  base_wdata;
	logic signed [NUM_W-1:0] acc_ext, acc30, base_ext, num_d;
	logic [CNT_W-1:0]   ev_eff;
	logic [DIV_W-1:0]   div_d;
	logic signed [NUM_W-1:0] mag_full;
	logic [DIV_W:0]     trial, trial_diff;
	logic               trial_ge;
	logic               sat;
	logic signed [AVG_W-1:0] avg_val;

	assign accept     = in_valid && in_ready;
	assign item_ok    = (int'(in_item.channel) < CHANNELS) &&
	                    (int'(in_item.sample_index) < SAMPLES);
	assign addr_in    = ADDR_W'(int'(in_item.channel) * SAMPLES + int'(in_item.sample_index));
	assign sweep_last = (cnt_q == ADDR_W'(DEPTH - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (in_item.operation)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_ACCUM: state_d = item_ok ? ST_FETCH : ST_IDLE;
						OP_READ:  state_d = item_ok ? ST_FETCH : ST_RESULT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_FETCH:  state_d = is_read_q ? ST_NUMER : ST_ACCUM;
			ST_ACCUM:  state_d = ST_IDLE;
			ST_NUMER:  state_d = ST_SETUP;
			ST_SETUP:  state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (step_q == STEP_W'(MAG_W - 1)) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	// State outputs: memory write enables, input ready, output load
	always_comb begin
		in_ready = 1'b0;
		sum_we   = 1'b0;
		base_we  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_CLEAR: begin
				sum_we  = 1'b1;
				base_we = (cnt_q < ADDR_W'(CHANNELS));
			end
			ST_ACCUM: begin
				sum_we  = 1'b1;
				base_we = base_win_q;
			end
			ST_RESULT: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Write port: the clearing sweep writes zero, accumulate writes sum plus sample
	always_comb begin
		if (state_q == ST_CLEAR) begin
			sum_waddr  = cnt_q;
			base_waddr = CH_W'(cnt_q);
			sum_wdata  = '0;
			base_wdata = '0;
		end else begin
			sum_waddr  = addr_q;
			base_waddr = ch_q;
			sum_wdata  = sum_rd_q + SUM_W'(sample_q);
			base_wdata = base_rd_q + BASE_W'(sample_q);
		end
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
		if (base_we) base_mem[base_waddr] <= base_wdata;
		sum_rd_q  <= sum_mem[addr_q];
		base_rd_q <= base_mem[ch_q];
	end

	// Numerator (30*acc - baseline) or acc, and divisor 30*N or N
	always_comb begin
		acc_ext  = NUM_W'(signed'(sum_rd_q));
		acc30    = (acc_ext <<< 5) - (acc_ext <<< 1);
		base_ext = NUM_W'(signed'(base_rd_q));
		num_d    = bl_en_q ? (acc30 - base_ext) : acc_ext;
		ev_eff   = (ev_cnt_q == '0) ? CNT_W'(1) : ev_cnt_q;
		div_d    = bl_en_q ? (DIV_W'({ev_eff, 5'b0}) - DIV_W'({ev_eff, 1'b0}))
		                   : DIV_W'(ev_eff);
		mag_full = num_q[NUM_W-1] ? -num_q : num_q;
	end

	// One restoring division step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial      = {rem_q, quo_q[MAG_W-1]};
		trial_diff = trial - {1'b0, div_q};
		trial_ge   = (trial >= {1'b0, div_q});
	end

	// Restore sign and clip to 16 bits
	always_comb begin
		sat = neg_q ? (quo_q > MAG_W'(32768)) : (quo_q > MAG_W'(32767));
		if (sat) begin
			avg_val = neg_q ? AVG_MIN : AVG_MAX;
		end else begin
			avg_val = neg_q ? signed'(~quo_q[AVG_W-1:0] + AVG_W'(1))
			                : signed'(quo_q[AVG_W-1:0]);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			step_q      <= '0;
			is_read_q   <= 1'b0;
			bl_en_q     <= 1'b1;
			ev_cnt_q    <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Advance the sweep; wrap to zero on its last entry
			if (state_q == ST_CLEAR) begin
				cnt_q <= sweep_last ? '0 : cnt_q + ADDR_W'(1);
			end
			if (state_q == ST_SETUP) begin
				step_q <= '0;
			end else if (state_q == ST_DIVIDE) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (accept) begin
				is_read_q <= (in_item.operation == OP_READ);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASELINE_ENABLE: bl_en_q  <= cfg_data[0];
					CFG_EVENT_COUNT:     ev_cnt_q <= cfg_data;
					default: ;
				endcase
			end
			// Hold the result until the out side takes it
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q     <= addr_in;
			ch_q       <= CH_W'(in_item.channel);
			base_win_q <= (int'(in_item.sample_index) < BASE_LEN);
			sample_q   <= in_item.sample;
		end
		if (state_q == ST_NUMER) begin
			num_q <= num_d;
			div_q <= div_d;
		end
		if (state_q == ST_IDLE) begin
			// An out-of-range read yields zero without running the divider
			neg_q <= 1'b0;
			quo_q <= '0;
		end else if (state_q == ST_SETUP) begin
			neg_q <= num_q[NUM_W-1];
			quo_q <= mag_full[MAG_W-1:0];
			rem_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			quo_q <= {quo_q[MAG_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
		if (load_out) begin
			out_q.average   <= avg_val;
			out_q.saturated <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[hdl/wab_checker.sv]
`timescale 1ns / 1ps

module wab_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input wab_pkg::in_item_t              in_item,
	input logic                           out_valid,
	input logic                           out_ready,
	input wab_pkg::out_item_t             out_item
);
	import wab_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed or dropped while stalled");

	// A clipped average sits at one of the two limits
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.saturated |->
			out_item.average == AVG_MAX || out_item.average == AVG_MIN)
		else $error("saturated flag with unclipped average");

	// Read and clear leave the block busy, so no input is taken right after either
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready &&
			(in_item.operation == OP_READ || in_item.operation == OP_CLEAR) |=> !in_ready)
		else $error("input taken right after a read or clear");

	// A new result follows a cycle in which no transfer was taken
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while input side was idle");

endmodule

bind waveform_averager_baseline wab_checker u_wab_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
	import wab_pkg::*;

	localparam int NUM_CH      = 37;
	localparam int NUM_POS     = 300;
	// One clear sweep covers every accumulator, one entry per cycle; pad it a little
	localparam int CLEAR_WAIT  = NUM_CH * NUM_POS + 64;
	// Leave room for a read to finish at the very end
	localparam int TAIL_CYCLES = 64;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int PHASE_ITEMS = 310;
	// Opcode the block leaves undefined; it must be dropped silently
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_item_t               in_item   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_item;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Idle and stall rates in percent, plus counters for stretches without any gaps
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int src_calm       = 0;
	int sink_calm      = 0;

	// Tracks every accumulator the way the block should, and queues the averages
	// that reads should return, oldest first.
	class average_tracker;
		logic signed [SUM_W-1:0]  sums [NUM_CH*NUM_POS];
		logic signed [BASE_W-1:0] base_sums [NUM_CH];
		bit                       baseline_on;
		logic [CNT_W-1:0]         divisor_reg;
		out_item_t                pending_averages [$];
		int                       mismatches;

		function new();
			wipe();
			baseline_on = 1'b1;
			divisor_reg = 8'd1;
			mismatches  = 0;
		endfunction

		function void wipe();
			foreach (sums[i]) sums[i] = '0;
			foreach (base_sums[i]) base_sums[i] = '0;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_BASELINE_ENABLE: baseline_on = data[0];
				CFG_EVENT_COUNT:     divisor_reg = data[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_item(in_item_t it);
			bit        hit;
			int        k;
			longint    acc, bsum, n, q;
			out_item_t want;
			hit = (it.channel < NUM_CH) && (it.sample_index < NUM_POS);
			k   = int'(it.channel) * NUM_POS + int'(it.sample_index);
			case (it.operation)
				OP_CLEAR: wipe();
				OP_ACCUM: begin
					if (hit) begin
						// Both sums wrap silently at their own widths
						sums[k] = sums[k] + SUM_W'($signed(it.sample));
						if (it.sample_index < BASE_LEN)
							base_sums[it.channel] = base_sums[it.channel]
								+ BASE_W'($signed(it.sample));
					end
				end
				OP_READ: begin
					q = 0;
					want.saturated = 1'b0;
					if (hit) begin
						// A zero count divides by one
						n   = (divisor_reg == 0) ? 1 : longint'(divisor_reg);
						acc = longint'(sums[k]);
						if (baseline_on) begin
							bsum = longint'(base_sums[it.channel]);
							q = (BASE_LEN * acc - bsum) / (BASE_LEN * n);
						end else begin
							q = acc / n;
						end
						if (q > AVG_MAX) begin
							q = longint'(AVG_MAX);
							want.saturated = 1'b1;
						end else if (q < AVG_MIN) begin
							q = longint'(AVG_MIN);
							want.saturated = 1'b1;
						end
					end
					want.average = AVG_W'(q);
					pending_averages.push_back(want);
				end
				default: ;
			endcase
		endfunction

		function void match_average(out_item_t got);
			out_item_t want;
			if (pending_averages.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got average %0d saturated %0b",
					$time, got.average, got.saturated);
				return;
			end
			want = pending_averages.pop_front();
			if (got.average !== want.average) begin
				mismatches++;
				$display("%0t: average expected %0d got %0d", $time, want.average, got.average);
			end
			if (got.saturated !== want.saturated) begin
				mismatches++;
				$display("%0t: saturated expected %0b got %0b", $time, want.saturated,
					got.saturated);
			end
		endfunction
	endclass

	average_tracker tracker;

	waveform_averager_baseline #(
		.CHANNELS(NUM_CH),
		.SAMPLES (NUM_POS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Check each result transfer, then pick the ready level for the next cycle.
	// Both happen at the edge, so the check sees the level that was on the wire.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_average(out_item);
		if (sink_calm > 0) begin
			sink_calm <= sink_calm - 1;
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
			if ($urandom_range(99) == 0)
				sink_calm <= $urandom_range(20, 80);
		end
	end

	// Hard stop in case the block hangs
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	function automatic in_item_t make_item(input logic [OP_W-1:0] op, input int ch,
		input int pos, input logic signed [SMP_W-1:0] smp);
		in_item_t it;
		it.operation    = op;
		it.channel      = ch[CH_FIELD_W-1:0];
		it.sample_index = pos[POS_W-1:0];
		it.sample       = smp;
		return it;
	endfunction

	// Mix rail values, full-range noise and small values near zero
	function automatic logic signed [SMP_W-1:0] draw_sample();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1: return SMP_W'($urandom);
			default: return SMP_W'($urandom_range(0, 2000)) - 16'sd1000;
		endcase
	endfunction

	// Present one item and hold it until the transfer; note it in the tracker.
	task automatic send_item(input in_item_t it);
		while (src_calm == 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.take_item(it);
		if (src_calm > 0)
			src_calm--;
		else if ($urandom_range(49) == 0)
			src_calm = $urandom_range(20, 60);
	endtask

	// Drop valid and hold off until every queued average has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_averages.size() != 0) @(posedge clk);
	endtask

	// Write both registers while the block is quiet. A clear gives no result, so
	// wait out a full sweep in case one is still running.
	task automatic apply_settings(input logic [CFG_DATA_W-1:0] enable_data,
		input logic [CFG_DATA_W-1:0] count);
		wait_drained();
		repeat (CLEAR_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BASELINE_ENABLE;
		cfg_data  <= enable_data;
		@(posedge clk);
		tracker.configure(CFG_BASELINE_ENABLE, enable_data);
		cfg_index <= CFG_EVENT_COUNT;
		cfg_data  <= count;
		@(posedge clk);
		tracker.configure(CFG_EVENT_COUNT, count);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	// One random phase: start from cleared sums, then mostly well-formed event sets
	// (a few events over a run of positions, then read the run back), with some
	// stray reads and noise mixed in.
	task automatic run_phase(input int quota, input bit with_wrap);
		int                      done, pick, ch, pos, start, len, events, reps;
		bit                      paused;
		logic signed [SMP_W-1:0] smp;
		in_item_t                it;
		done   = 1;
		paused = 1'b0;
		send_item(make_item(OP_CLEAR, 0, 0, 16'sd0));
		if (with_wrap) begin
			// Pile rail values on one spot until the 24-bit sum wraps around
			ch   = $urandom_range(0, NUM_CH - 1);
			pos  = $urandom_range(0, NUM_POS - 1);
			smp  = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			reps = $urandom_range(257, 300);
			repeat (reps) send_item(make_item(OP_ACCUM, ch, pos, smp));
			send_item(make_item(OP_READ, ch, pos, 16'sd0));
			done += reps + 1;
		end
		while (done < quota) begin
			if (!paused && done >= quota / 2) begin
				// Hold off the sender until every result is back
				wait_drained();
				paused = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 12) begin
				// Noise: any opcode but clear, any field value
				it = make_item(OP_W'($urandom_range(1, 3)), $urandom_range(0, 63),
					$urandom_range(0, 511), draw_sample());
				send_item(it);
				if (it.operation == OP_READ || (it.operation == OP_ACCUM &&
					it.channel < NUM_CH && it.sample_index < NUM_POS))
					done++;
			end else if (pick < 22) begin
				send_item(make_item(OP_READ, $urandom_range(0, NUM_CH - 1),
					$urandom_range(0, NUM_POS - 1), draw_sample()));
				done++;
			end else begin
				ch = $urandom_range(0, NUM_CH - 1);
				if ($urandom_range(1) == 0) begin
					// Baseline window, up to just past its end
					start = 0;
					len   = $urandom_range(4, 32);
				end else begin
					start = $urandom_range(0, NUM_POS - 16);
					len   = $urandom_range(4, 16);
				end
				events = $urandom_range(1, 3);
				repeat (events) begin
					for (int p = start; p < start + len; p++)
						send_item(make_item(OP_ACCUM, ch, p, draw_sample()));
				end
				for (int p = start; p < start + len; p++)
					send_item(make_item(OP_READ, ch, p, draw_sample()));
				done += (events + 1) * len;
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Baseline off (upper data bits set to show they are dropped), divide by one
		apply_settings(8'hFE, 8'd1);

		// Rails at both corner entries: two minimum samples saturate low,
		// two maximum samples saturate high
		send_item(make_item(OP_ACCUM, 0, 0, 16'sh7FFF));
		send_item(make_item(OP_ACCUM, NUM_CH - 1, NUM_POS - 1, 16'sh8000));
		send_item(make_item(OP_ACCUM, NUM_CH - 1, NUM_POS - 1, 16'sh8000));
		send_item(make_item(OP_READ, NUM_CH - 1, NUM_POS - 1, 16'sd0));
		send_item(make_item(OP_ACCUM, 0, 0, 16'sh7FFF));
		send_item(make_item(OP_READ, 0, 0, 16'sd0));
		// Out-of-range accumulates must leave every sum alone
		send_item(make_item(OP_ACCUM, 63, 0, 16'sh1234));
		send_item(make_item(OP_ACCUM, 0, 511, 16'sh1234));
		send_item(make_item(OP_ACCUM, NUM_CH, NUM_POS, 16'sh1234));
		// Out-of-range reads return zero, unsaturated
		send_item(make_item(OP_READ, 63, 0, 16'sd0));
		send_item(make_item(OP_READ, 0, NUM_POS, 16'sd0));
		send_item(make_item(OP_READ, NUM_CH, NUM_POS - 1, 16'sd0));
		// Unused opcode with every field bit set: no result
		send_item(make_item(OP_UNUSED, 63, 511, 16'shFFFF));
		// Never-written entry reads as zero
		send_item(make_item(OP_READ, 0, 1, 16'sd0));
		// Last baseline position and the first one past it
		send_item(make_item(OP_ACCUM, 5, BASE_LEN - 1, 16'shFFFF));
		send_item(make_item(OP_READ, 5, BASE_LEN - 1, 16'sd0));
		send_item(make_item(OP_ACCUM, 5, BASE_LEN, 16'sd1));
		send_item(make_item(OP_READ, 5, BASE_LEN, 16'sd0));
		// Clear, then the corners must read back as zero
		send_item(make_item(OP_CLEAR, 0, 0, 16'sd0));
		send_item(make_item(OP_READ, 0, 0, 16'sd0));
		send_item(make_item(OP_READ, NUM_CH - 1, NUM_POS - 1, 16'sd0));

		// Baseline on, largest nominal count, no gaps on either side
		apply_settings(8'h01, 8'd128);
		set_idling(0, 0);
		run_phase(PHASE_ITEMS, 1'b0);

		// Zero count acts as one; sender idles about half the time
		apply_settings(8'hA5, 8'd0);
		set_idling(52, 0);
		run_phase(PHASE_ITEMS, 1'b0);

		// Baseline off, count above the nominal range; receiver stalls
		apply_settings(8'h5A, 8'd255);
		set_idling(0, 52);
		run_phase(PHASE_ITEMS, 1'b0);

		// Odd divisor with gaps on both sides
		apply_settings(8'hFF, 8'd7);
		set_idling(34, 34);
		run_phase(PHASE_ITEMS, 1'b0);

		// Accumulator wrap with a plain divide by one
		apply_settings(8'h00, 8'd1);
		set_idling(34, 34);
		run_phase(PHASE_ITEMS, 1'b1);

		// Accumulator wrap again, now through the baseline path
		apply_settings(8'h81, 8'd1);
		set_idling(52, 52);
		run_phase(PHASE_ITEMS, 1'b1);

		// Drain, let any trailing work settle, then report
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_averages.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
hdl/wab_pkg.sv
hdl/waveform_averager_baseline.sv
hdl/wab_checker.sv
sim/tb.sv
